FILE: hw/rtl/u2u_pkg.sv
package u2u_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_BAD_CONT = 2'd2;

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_present;
    logic        text_done;
    logic [1:0]  decode_status;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

FILE: hw/rtl/u2u_decode.sv
module u2u_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              final_byte,
  output u2u_pkg::push_t    push
);

  logic [20:0] pending_point, pending_point_next;
  logic [1:0]  bytes_still_needed, bytes_still_needed_next;
  logic [1:0]  halted_status, halted_status_next;

  logic [20:0] cp;
  logic [20:0] cp_off;
  logic        emit;
  logic [1:0]  status;
  u2u_pkg::push_t res;

  always_comb begin
    pending_point_next      = pending_point;
    bytes_still_needed_next = bytes_still_needed;
    halted_status_next      = halted_status;
    cp                      = '0;
    emit                    = 1'b0;
    res                     = '0;

    if (halted_status == u2u_pkg::ST_OK) begin
      if (bytes_still_needed == 2'd0) begin
        priority if (text_byte < 8'h80) begin
          cp   = {13'd0, text_byte};
          emit = 1'b1;
        end else if (text_byte < 8'hC0 || text_byte >= 8'hF7) begin
          halted_status_next = u2u_pkg::ST_BAD_LEAD;
        end else if (text_byte >= 8'hF0) begin
          pending_point_next      = {18'd0, text_byte[2:0]};
          bytes_still_needed_next = 2'd3;
        end else if (text_byte >= 8'hE0) begin
          pending_point_next      = {17'd0, text_byte[3:0]};
          bytes_still_needed_next = 2'd2;
        end else begin
          pending_point_next      = {16'd0, text_byte[4:0]};
          bytes_still_needed_next = 2'd1;
        end
      end else begin
        if (text_byte[7:6] != 2'b10) begin
          halted_status_next      = u2u_pkg::ST_BAD_CONT;
          bytes_still_needed_next = 2'd0;
          pending_point_next      = '0;
        end else begin
          cp                      = {pending_point[14:0], text_byte[5:0]};
          pending_point_next      = cp;
          bytes_still_needed_next = bytes_still_needed - 2'd1;
          if (bytes_still_needed == 2'd1) begin
            emit               = 1'b1;
            pending_point_next = '0;
          end
        end
      end
    end

    cp_off = cp - u2u_pkg::SUPP_BASE;
    if (emit) begin
      if (cp >= u2u_pkg::SUPP_BASE) begin
        res.first.code_unit     = u2u_pkg::HI_SURR | {6'd0, cp_off[19:10]};
        res.first.unit_present  = 1'b1;
        res.second.code_unit    = u2u_pkg::LO_SURR | {6'd0, cp_off[9:0]};
        res.second.unit_present = 1'b1;
        res.count               = 2'd2;
      end else begin
        res.first.code_unit    = cp[15:0];
        res.first.unit_present = 1'b1;
        res.count              = 2'd1;
      end
    end

    status = halted_status_next;
    if (status == u2u_pkg::ST_OK && bytes_still_needed_next != 2'd0) begin
      status = u2u_pkg::ST_BAD_CONT;
    end

    if (final_byte) begin
      unique case (res.count)
        2'd2: begin
          res.second.text_done     = 1'b1;
          res.second.decode_status = status;
        end
        2'd1: begin
          res.first.text_done     = 1'b1;
          res.first.decode_status = status;
        end
        default: begin
          res.first.text_done     = 1'b1;
          res.first.decode_status = status;
          res.count               = 2'd1;
        end
      endcase
      pending_point_next      = '0;
      bytes_still_needed_next = 2'd0;
      halted_status_next      = u2u_pkg::ST_OK;
    end
  end

  assign push = accept ? res : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_point      <= '0;
      bytes_still_needed <= '0;
      halted_status      <= u2u_pkg::ST_OK;
    end else if (accept) begin
      pending_point      <= pending_point_next;
      bytes_still_needed <= bytes_still_needed_next;
      halted_status      <= halted_status_next;
    end
  end

`ifndef SYNTHESIS
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    accept && final_byte |=> pending_point == '0 && bytes_still_needed == 2'd0
      && halted_status == u2u_pkg::ST_OK)
    else $error("state not cleared after end of text");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    accept && halted_status != u2u_pkg::ST_OK |->
      !push.first.unit_present && push.count == (final_byte ? 2'd1 : 2'd0))
    else $error("output while halted");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 && !push.first.text_done |->
      push.first.decode_status == u2u_pkg::ST_OK)
    else $error("status on a result that does not end the text");
`endif

endmodule

FILE: hw/rtl/u2u_outq.sv
module u2u_outq #(
  parameter int unsigned DEPTH = u2u_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  u2u_pkg::push_t     push,
  input  logic               take,
  output logic               room,
  output logic               head_valid,
  output u2u_pkg::result_t   head
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  u2u_pkg::result_t q [DEPTH];
  u2u_pkg::result_t q_next [DEPTH];
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] base;
  logic          pop;

  assign head_valid = count != '0;
  assign head       = q[0];
  assign pop        = head_valid && take;
  assign room       = count <= CW'(DEPTH - 2);

  always_comb begin
    base = count - CW'(pop);
    for (int i = 0; i < DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (push.count != 2'd0 && base == CW'(i)) begin
        q_next[i] = push.first;
      end
      if (push.count == 2'd2 && base + CW'(1) == CW'(i)) begin
        q_next[i] = push.second;
      end
    end
    count_next = base + CW'(push.count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |=> count != '0)
    else $error("pushed result lost");
`endif

endmodule

FILE: hw/rtl/utf8_to_utf16_decoder_unit.sv
// a result enters the registered queue when its item is accepted and is offered from the head
// throughput: one byte per cycle while the queue has room; a surrogate pair yields two
// output units, so a queue of results absorbs the extra unit and holds off input while
// fewer than two queue slots are free
// reset: synchronous, active high; clears decode state and empties the queue
module utf8_to_utf16_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = u2u_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // code_unit
  output logic [2:0]  m_axis_tuser,   // unit_present, decode_status[1:0]
  output logic        m_axis_tlast    // text_done
);

  u2u_pkg::push_t   push;
  u2u_pkg::result_t head;
  logic             room;
  logic             accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  u2u_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (s_axis_tdata),
    .final_byte (s_axis_tlast),
    .push       (push)
  );

  u2u_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .take       (m_axis_tready),
    .room       (room),
    .head_valid (m_axis_tvalid),
    .head       (head)
  );

  assign m_axis_tdata = head.code_unit;
  assign m_axis_tuser = {head.decode_status, head.unit_present};
  assign m_axis_tlast = head.text_done;

endmodule

FILE: tb/utf8_to_utf16_decoder_unit_tb.sv
module utf8_to_utf16_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned ITEM_GOAL = 1450;
  localparam int unsigned CALM_AFTER = 1300;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct packed {
    logic [7:0]       text_byte;
    logic             final_byte;
    logic             typed;
    u2u_pkg::result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // text_byte
  logic        s_axis_tlast = 1'b0;    // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // code_unit
  logic [2:0]  m_axis_tuser;           // unit_present, decode_status[1:0]
  logic        m_axis_tlast;           // text_done

  // typed expectation travels beside the item
  logic             drv_typed = 1'b0;
  u2u_pkg::result_t drv_want = '0;

  // decoder state of the predictor
  logic [20:0] pend_cp = '0;
  logic [1:0]  cont_left = '0;
  logic [1:0]  halt_code = u2u_pkg::ST_OK;

  u2u_pkg::result_t due_units[$];
  stim_row_t        dir_rows[$];
  logic [7:0]       text_q[$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned live_items = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  u2u_pkg::result_t mon_r0;
  u2u_pkg::result_t mon_r1;
  u2u_pkg::result_t mon_want;
  int               mon_n;

  utf8_to_utf16_decoder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int decode_byte(input logic [7:0] b, input logic fin,
                                     output u2u_pkg::result_t r0,
                                     output u2u_pkg::result_t r1);
    int          n;
    logic        emit;
    logic [20:0] cp;
    logic [20:0] v;
    logic [1:0]  st;
    n = 0;
    emit = 1'b0;
    cp = '0;
    r0 = '0;
    r1 = '0;
    if (halt_code == u2u_pkg::ST_OK) begin
      if (cont_left == 2'd0) begin
        if (b < 8'h80) begin
          emit = 1'b1;
          cp = {13'd0, b};
        end else if (b < 8'hC0 || b >= 8'hF7) begin
          halt_code = u2u_pkg::ST_BAD_LEAD;
        end else if (b >= 8'hF0) begin
          pend_cp = {18'd0, b[2:0]};
          cont_left = 2'd3;
        end else if (b >= 8'hE0) begin
          pend_cp = {17'd0, b[3:0]};
          cont_left = 2'd2;
        end else begin
          pend_cp = {16'd0, b[4:0]};
          cont_left = 2'd1;
        end
      end else if (b[7:6] != 2'b10) begin
        halt_code = u2u_pkg::ST_BAD_CONT;
        cont_left = 2'd0;
        pend_cp = '0;
      end else begin
        pend_cp = {pend_cp[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          emit = 1'b1;
          cp = pend_cp;
          pend_cp = '0;
        end
      end
    end
    if (emit) begin
      if (cp >= u2u_pkg::SUPP_BASE) begin
        v = cp - u2u_pkg::SUPP_BASE;
        r0 = '{u2u_pkg::HI_SURR + {6'd0, v[19:10]}, 1'b1, 1'b0, u2u_pkg::ST_OK};
        r1 = '{u2u_pkg::LO_SURR + {6'd0, v[9:0]}, 1'b1, 1'b0, u2u_pkg::ST_OK};
        n = 2;
      end else begin
        r0 = '{cp[15:0], 1'b1, 1'b0, u2u_pkg::ST_OK};
        n = 1;
      end
    end
    if (fin) begin
      st = halt_code;
      if (st == u2u_pkg::ST_OK && cont_left != 2'd0) st = u2u_pkg::ST_BAD_CONT;
      if (n == 0) n = 1;
      if (n == 2) begin
        r1.text_done = 1'b1;
        r1.decode_status = st;
      end else begin
        r0.text_done = 1'b1;
        r0.decode_status = st;
      end
      pend_cp = '0;
      cont_left = 2'd0;
      halt_code = u2u_pkg::ST_OK;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d units outstanding", due_units.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // predict accepted items first, then check the result of this edge
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      live_items++;
      mon_n = decode_byte(s_axis_tdata, s_axis_tlast, mon_r0, mon_r1);
      if (drv_typed) begin
        due_units.insert(due_units.size(), drv_want);
      end else begin
        if (mon_n >= 1) due_units.insert(due_units.size(), mon_r0);
        if (mon_n == 2) due_units.insert(due_units.size(), mon_r1);
      end
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_units.size() == 0) begin
        report_mismatch("unexpected unit", m_axis_tdata, 16'h0000);
      end else begin
        mon_want = due_units.pop_front();
        if (m_axis_tdata !== mon_want.code_unit)
          report_mismatch("code_unit", m_axis_tdata, mon_want.code_unit);
        if (m_axis_tuser[0] !== mon_want.unit_present)
          report_mismatch("unit_present", 16'(m_axis_tuser[0]), 16'(mon_want.unit_present));
        if (m_axis_tuser[2:1] !== mon_want.decode_status)
          report_mismatch("decode_status", 16'(m_axis_tuser[2:1]),
                          16'(mon_want.decode_status));
        if (m_axis_tlast !== mon_want.text_done)
          report_mismatch("text_done", 16'(m_axis_tlast), 16'(mon_want.text_done));
      end
    end
  end

  // receiver: random stall bursts and one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic fin, input logic typed,
                           input u2u_pkg::result_t want);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    drv_typed <= typed;
    drv_want <= want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic fin, input logic typed,
                         input logic [15:0] unit, input logic present, input logic done,
                         input logic [1:0] st);
    dir_rows.insert(dir_rows.size(), '{b, fin, typed, '{unit, present, done, st}});
  endtask

  function automatic logic [7:0] make_lead(input int len);
    case (len)
      2: return 8'hC0 + 8'($urandom_range(0, 31));
      3: return 8'hE0 + 8'($urandom_range(0, 15));
      default: return 8'hF0 + 8'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic add_char();
    int len;
    len = $urandom_range(1, 4);
    if (len == 1) text_q.insert(text_q.size(), 8'($urandom_range(0, 127)));
    else text_q.insert(text_q.size(), make_lead(len));
    repeat (len - 1) text_q.insert(text_q.size(), cont_byte());
  endtask

  task automatic add_noise(input int mode);
    logic [7:0] b;
    if (mode < 88) begin
      text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
    end else begin
      text_q.insert(text_q.size(), make_lead($urandom_range(2, 4)));
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      text_q.insert(text_q.size(), b);
    end
  endtask

  // cut off a multi-byte character at the end of the text
  task automatic add_partial();
    int len;
    len = $urandom_range(2, 4);
    text_q.insert(text_q.size(), make_lead(len));
    repeat ($urandom_range(0, len - 2)) text_q.insert(text_q.size(), cont_byte());
  endtask

  task automatic build_text();
    int nch;
    int mode;
    int k;
    text_q.delete();
    nch = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
    mode = $urandom_range(0, 99);
    for (k = 0; k < nch; k++) begin
      if (mode >= 80 && mode < 94 && k == nch / 2) add_noise(mode);
      add_char();
    end
    if (mode >= 94) add_partial();
  endtask

  initial begin
    int k;
    int text_cnt;

    // byte, last, typed, code_unit, present, done, status
    add_row(8'h00, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h7F, 1'b0, 1'b1, 16'h007F, 1'b1, 1'b0, u2u_pkg::ST_OK);
    // overlong zero
    add_row(8'hC0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'hDF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    // encoded surrogate passes through
    add_row(8'hED, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'hA0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    // lowest supplementary point
    add_row(8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h90, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    // highest lead, masked pair, text ends on the pair
    add_row(8'hF6, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'hBF, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    // bad lead bytes
    add_row(8'hFF, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, u2u_pkg::ST_BAD_LEAD);
    add_row(8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h41, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, u2u_pkg::ST_BAD_LEAD);
    // bad continuation, then halted
    add_row(8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h41, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, u2u_pkg::ST_OK);
    add_row(8'h42, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, u2u_pkg::ST_BAD_CONT);
    // truncated at end of text
    add_row(8'hC3, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, u2u_pkg::ST_BAD_CONT);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].text_byte, dir_rows[i].final_byte, dir_rows[i].typed,
                dir_rows[i].want);

    text_cnt = 0;
    while (live_items < ITEM_GOAL) begin
      if (live_items > CALM_AFTER) calm = 1'b1;
      if (text_cnt == 20) hold_req = 1'b1;
      if (text_cnt == 40) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (due_units.size() != 0);
      end
      build_text();
      for (k = 0; k < text_q.size(); k++)
        send_item(text_q[k], k == text_q.size() - 1, 1'b0, '0);
      text_cnt++;
    end

    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (due_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
